// ----- hw/rtl/cau_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int CAU_DATA_WIDTH  = 32;
    localparam int CAU_FRAC_BITS   = 16;
    localparam int CAU_QUEUE_DEPTH = 4;
    localparam int CAU_MUL_SLOTS   = 6;

    typedef enum logic [2:0] {
        OP_NEG   = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_SCALE = 3'd4,
        OP_DIVC  = 3'd5,
        OP_DIVR  = 3'd6,
        OP_SQRT  = 3'd7
    } t_op;

    typedef struct packed {
        t_op  op;
        logic div_zero;
        logic re_zero;
    } t_ctrl;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_FORM,
        BK_SQRT,
        BK_DIV,
        BK_DONE
    } t_back_state;

    typedef enum logic [1:0] {
        SQ_AXIS,
        SQ_MOD,
        SQ_ROOT
    } t_sq_phase;

endpackage
`default_nettype wire

// ----- hw/rtl/cau_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front
// Input stage: register each beat and classify it (zero divisor, zero real
// part) before it enters the job queue.
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int DW = cau_pkg::CAU_DATA_WIDTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [2:0]        i_op,
    input  wire logic [4*DW-1:0]   i_opnd,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output cau_pkg::t_ctrl         o_ctrl,
    output logic [4*DW-1:0]        o_opnd
);

    logic                 r_valid;
    cau_pkg::t_ctrl       r_ctrl;
    logic [4*DW-1:0]      r_opnd;
    cau_pkg::t_ctrl       w_ctrl;
    logic [DW-1:0]        w_ar;
    logic [DW-1:0]        w_br;
    logic [DW-1:0]        w_bi;

    always_comb begin
        w_ar            = i_opnd[0 +: DW];
        w_br            = i_opnd[2*DW +: DW];
        w_bi            = i_opnd[3*DW +: DW];
        w_ctrl.op       = cau_pkg::t_op'(i_op);
        w_ctrl.div_zero = ((w_ctrl.op == cau_pkg::OP_DIVC) && (w_br == '0) && (w_bi == '0))
                       || ((w_ctrl.op == cau_pkg::OP_DIVR) && (w_br == '0));
        w_ctrl.re_zero  = (w_ar == '0);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_opnd  = r_opnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctrl <= w_ctrl;
            r_opnd <= i_opnd;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/cau_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cau_queue
// Small register FIFO between the front and back stages.
// ----------------------------------------------------------------------------
module cau_queue #(
    parameter int EW    = 8,
    parameter int DEPTH = cau_pkg::CAU_QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [EW-1:0] i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [EW-1:0]      o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [EW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/cau_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cau_back
// Execution stage: shared multiplier, bit-serial square root and a pair of
// bit-serial dividers, then saturation into a registered output beat.
// ----------------------------------------------------------------------------
module cau_back #(
    parameter int DW = cau_pkg::CAU_DATA_WIDTH,
    parameter int FB = cau_pkg::CAU_FRAC_BITS
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire cau_pkg::t_ctrl  i_ctrl,
    input  wire logic [4*DW-1:0] i_opnd,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [DW-1:0]        o_res_re,
    output logic [DW-1:0]        o_res_im,
    output logic                 o_div_zero,
    output logic                 o_saturated
);

    localparam int PW  = 2 * DW;
    localparam int SW  = 2 * DW + 2;
    localparam int ND  = 2 * DW + FB;
    localparam int DD  = 2 * DW;
    localparam int SRR = (2 * DW > DW + FB + 2) ? 2 * DW : DW + FB + 2;
    localparam int SR  = SRR + (SRR % 2);
    localparam int RT  = SR / 2;
    localparam int MW  = ND;
    localparam int CW  = $clog2(ND + 1);
    localparam logic [MW-1:0] LIM_POS = MW'({(DW-1){1'b1}});
    localparam logic [MW-1:0] LIM_NEG = LIM_POS + MW'(1);

    cau_pkg::t_back_state r_state, n_state;
    cau_pkg::t_ctrl       r_ctrl;
    cau_pkg::t_sq_phase   r_sq_phase;

    logic signed [DW-1:0] r_ar, r_ai, r_br, r_bi;
    logic [DW-1:0]        w_ar_m, w_ai_m, w_br_m, w_bi_m;
    logic                 w_ar_n, w_ai_n, w_br_n, w_bi_n;
    logic [CW-1:0]        r_cnt;
    logic [PW-1:0]        r_prod [cau_pkg::CAU_MUL_SLOTS];
    logic [DW-1:0]        w_mx, w_my;
    logic [PW-1:0]        w_det;

    logic signed [SW-1:0] w_sp0, w_sp1, w_sp2, w_sp3;
    logic signed [SW-1:0] w_re_s, w_im_s;
    logic [SW-1:0]        w_re_abs, w_im_abs, w_re_mag, w_im_mag;

    logic                 r_re_neg, r_im_neg, r_dz;
    logic [MW-1:0]        r_re_mag, r_im_mag;

    logic [ND-1:0]        r_dnum [2];
    logic [DD-1:0]        r_drem [2];
    logic [ND-1:0]        r_dq   [2];
    logic [DD-1:0]        r_dden;
    logic [DD:0]          w_dtrial [2];
    logic [DD:0]          w_ddiff  [2];
    logic                 w_dge    [2];
    logic [DD-1:0]        w_drem_n [2];
    logic [ND-1:0]        w_dq_n   [2];
    logic                 w_div_last;

    logic [SR-1:0]        r_sq_rad;
    logic [RT:0]          r_sq_rem;
    logic [RT-1:0]        r_sq_root;
    logic [RT+2:0]        w_sq_cur, w_sq_trial, w_sq_diff;
    logic                 w_sq_ge;
    logic [RT-1:0]        w_sq_root_n;
    logic [RT-1:0]        w_sq_half;
    logic [DW:0]          w_sq_sum;
    logic                 w_sq_last;

    logic                 r_out_valid, r_out_dz, r_out_sat;
    logic [DW-1:0]        r_out_re, r_out_im;
    logic                 w_out_load;
    logic                 w_over_re, w_over_im;
    logic [MW-1:0]        w_lim_re, w_lim_im;
    logic [DW-1:0]        w_val_re, w_val_im, w_fin_re, w_fin_im;

    // operand magnitudes and signs
    always_comb begin
        w_ar_n = r_ar[DW-1];
        w_ai_n = r_ai[DW-1];
        w_br_n = r_br[DW-1];
        w_bi_n = r_bi[DW-1];
        w_ar_m = w_ar_n ? unsigned'(-r_ar) : unsigned'(r_ar);
        w_ai_m = w_ai_n ? unsigned'(-r_ai) : unsigned'(r_ai);
        w_br_m = w_br_n ? unsigned'(-r_br) : unsigned'(r_br);
        w_bi_m = w_bi_n ? unsigned'(-r_bi) : unsigned'(r_bi);
    end

    always_comb begin
        case (r_cnt[2:0])
            3'd0: begin w_mx = w_ar_m; w_my = w_br_m; end
            3'd1: begin w_mx = w_ai_m; w_my = w_bi_m; end
            3'd2: begin w_mx = w_ai_m; w_my = w_br_m; end
            3'd3: begin w_mx = w_ar_m; w_my = w_bi_m; end
            3'd4: begin
                w_mx = (r_ctrl.op == cau_pkg::OP_SQRT) ? w_ar_m : w_br_m;
                w_my = w_mx;
            end
            default: begin
                w_mx = (r_ctrl.op == cau_pkg::OP_SQRT) ? w_ai_m : w_bi_m;
                w_my = w_mx;
            end
        endcase
    end

    // combine products and linear terms
    always_comb begin
        w_det = r_prod[4] + r_prod[5];
        w_sp0 = (w_ar_n ^ w_br_n) ? -$signed({2'b00, r_prod[0]}) : $signed({2'b00, r_prod[0]});
        w_sp1 = (w_ai_n ^ w_bi_n) ? -$signed({2'b00, r_prod[1]}) : $signed({2'b00, r_prod[1]});
        w_sp2 = (w_ai_n ^ w_br_n) ? -$signed({2'b00, r_prod[2]}) : $signed({2'b00, r_prod[2]});
        w_sp3 = (w_ar_n ^ w_bi_n) ? -$signed({2'b00, r_prod[3]}) : $signed({2'b00, r_prod[3]});
        case (r_ctrl.op)
            cau_pkg::OP_NEG: begin
                w_re_s = -SW'(r_ar);
                w_im_s = -SW'(r_ai);
            end
            cau_pkg::OP_ADD: begin
                w_re_s = SW'(r_ar) + SW'(r_br);
                w_im_s = SW'(r_ai) + SW'(r_bi);
            end
            cau_pkg::OP_SUB: begin
                w_re_s = SW'(r_ar) - SW'(r_br);
                w_im_s = SW'(r_ai) - SW'(r_bi);
            end
            cau_pkg::OP_MUL: begin
                w_re_s = w_sp0 - w_sp1;
                w_im_s = w_sp2 + w_sp3;
            end
            cau_pkg::OP_SCALE: begin
                w_re_s = w_sp0;
                w_im_s = w_sp2;
            end
            cau_pkg::OP_DIVC: begin
                w_re_s = w_sp0 + w_sp1;
                w_im_s = w_sp2 - w_sp3;
            end
            default: begin
                w_re_s = '0;
                w_im_s = '0;
            end
        endcase
        w_re_abs = w_re_s[SW-1] ? unsigned'(-w_re_s) : unsigned'(w_re_s);
        w_im_abs = w_im_s[SW-1] ? unsigned'(-w_im_s) : unsigned'(w_im_s);
        if (r_ctrl.op inside {cau_pkg::OP_MUL, cau_pkg::OP_SCALE}) begin
            w_re_mag = w_re_abs >> FB;
            w_im_mag = w_im_abs >> FB;
        end else begin
            w_re_mag = w_re_abs;
            w_im_mag = w_im_abs;
        end
    end

    // divider step, two lanes sharing the divisor
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_dtrial[k] = {r_drem[k], r_dnum[k][ND-1]};
            w_dge[k]    = (w_dtrial[k] >= {1'b0, r_dden});
            w_ddiff[k]  = w_dtrial[k] - {1'b0, r_dden};
            w_drem_n[k] = w_dge[k] ? w_ddiff[k][DD-1:0] : w_dtrial[k][DD-1:0];
            w_dq_n[k]   = {r_dq[k][ND-2:0], w_dge[k]};
        end
        w_div_last = (r_cnt == CW'(ND - 1));
    end

    // square-root step, one result bit per cycle
    always_comb begin
        w_sq_cur    = {r_sq_rem, r_sq_rad[SR-1 -: 2]};
        w_sq_trial  = {1'b0, r_sq_root, 2'b01};
        w_sq_ge     = (w_sq_cur >= w_sq_trial);
        w_sq_diff   = w_sq_cur - w_sq_trial;
        w_sq_root_n = {r_sq_root[RT-2:0], w_sq_ge};
        w_sq_half   = w_sq_root_n >> 1;
        w_sq_sum    = (DW + 1)'(w_sq_root_n) + (DW + 1)'(w_ar_m);
        w_sq_last   = (r_cnt == CW'(RT - 1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cau_pkg::BK_IDLE: begin
                if (i_valid) begin
                    if (i_ctrl.op inside {cau_pkg::OP_NEG, cau_pkg::OP_ADD, cau_pkg::OP_SUB}) begin
                        n_state = cau_pkg::BK_FORM;
                    end else begin
                        n_state = cau_pkg::BK_MUL;
                    end
                end
            end
            cau_pkg::BK_MUL: begin
                if (r_cnt[2:0] == 3'(cau_pkg::CAU_MUL_SLOTS - 1)) begin
                    n_state = cau_pkg::BK_FORM;
                end
            end
            cau_pkg::BK_FORM: begin
                if (r_ctrl.op inside {cau_pkg::OP_DIVC, cau_pkg::OP_DIVR}) begin
                    n_state = r_ctrl.div_zero ? cau_pkg::BK_DONE : cau_pkg::BK_DIV;
                end else if (r_ctrl.op == cau_pkg::OP_SQRT) begin
                    n_state = cau_pkg::BK_SQRT;
                end else begin
                    n_state = cau_pkg::BK_DONE;
                end
            end
            cau_pkg::BK_SQRT: begin
                if (w_sq_last) begin
                    case (r_sq_phase)
                        cau_pkg::SQ_AXIS: n_state = cau_pkg::BK_DONE;
                        cau_pkg::SQ_ROOT: n_state = cau_pkg::BK_DIV;
                        default:          n_state = cau_pkg::BK_SQRT;
                    endcase
                end
            end
            cau_pkg::BK_DIV: begin
                if (w_div_last) begin
                    n_state = cau_pkg::BK_DONE;
                end
            end
            cau_pkg::BK_DONE: begin
                if (w_out_load) begin
                    n_state = cau_pkg::BK_IDLE;
                end
            end
            default: n_state = cau_pkg::BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ready    = (r_state == cau_pkg::BK_IDLE);
        w_out_load = (r_state == cau_pkg::BK_DONE) && (!r_out_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cau_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            cau_pkg::BK_IDLE: begin
                if (i_valid) begin
                    r_ctrl <= i_ctrl;
                    r_ar   <= i_opnd[0 +: DW];
                    r_ai   <= i_opnd[DW +: DW];
                    r_br   <= i_opnd[2*DW +: DW];
                    r_bi   <= i_opnd[3*DW +: DW];
                    r_cnt  <= '0;
                end
            end
            cau_pkg::BK_MUL: begin
                r_prod[r_cnt[2:0]] <= w_mx * w_my;
                r_cnt              <= r_cnt + CW'(1);
            end
            cau_pkg::BK_FORM: begin
                r_cnt     <= '0;
                r_drem[0] <= '0;
                r_drem[1] <= '0;
                r_dq[0]   <= '0;
                r_dq[1]   <= '0;
                r_sq_rem  <= '0;
                r_sq_root <= '0;
                r_dz      <= 1'b0;
                r_re_neg  <= w_re_s[SW-1];
                r_im_neg  <= w_im_s[SW-1];
                r_re_mag  <= MW'(w_re_mag);
                r_im_mag  <= MW'(w_im_mag);
                case (r_ctrl.op)
                    cau_pkg::OP_DIVC: begin
                        r_dz      <= r_ctrl.div_zero;
                        r_re_mag  <= '0;
                        r_im_mag  <= '0;
                        r_dnum[0] <= ND'(w_re_abs) << FB;
                        r_dnum[1] <= ND'(w_im_abs) << FB;
                        r_dden    <= DD'(w_det);
                        if (r_ctrl.div_zero) begin
                            r_re_neg <= 1'b0;
                            r_im_neg <= 1'b0;
                        end
                    end
                    cau_pkg::OP_DIVR: begin
                        r_dz      <= r_ctrl.div_zero;
                        r_re_mag  <= '0;
                        r_im_mag  <= '0;
                        r_re_neg  <= r_ctrl.div_zero ? 1'b0 : (w_ar_n ^ w_br_n);
                        r_im_neg  <= r_ctrl.div_zero ? 1'b0 : (w_ai_n ^ w_br_n);
                        r_dnum[0] <= ND'(w_ar_m) << FB;
                        r_dnum[1] <= ND'(w_ai_m) << FB;
                        r_dden    <= DD'(w_br_m);
                    end
                    cau_pkg::OP_SQRT: begin
                        if (r_ctrl.re_zero) begin
                            r_sq_rad   <= SR'(w_ai_m) << (FB - 1);
                            r_sq_phase <= cau_pkg::SQ_AXIS;
                        end else begin
                            r_sq_rad   <= SR'(w_det);
                            r_sq_phase <= cau_pkg::SQ_MOD;
                        end
                    end
                    default: ;
                endcase
            end
            cau_pkg::BK_SQRT: begin
                r_sq_rem  <= w_sq_ge ? w_sq_diff[RT:0] : w_sq_cur[RT:0];
                r_sq_root <= w_sq_root_n;
                r_sq_rad  <= r_sq_rad << 2;
                r_cnt     <= r_cnt + CW'(1);
                if (w_sq_last) begin
                    r_cnt     <= '0;
                    r_sq_rem  <= '0;
                    r_sq_root <= '0;
                    case (r_sq_phase)
                        cau_pkg::SQ_MOD: begin
                            r_sq_rad   <= SR'(w_sq_sum) << (FB + 1);
                            r_sq_phase <= cau_pkg::SQ_ROOT;
                        end
                        cau_pkg::SQ_AXIS: begin
                            r_re_mag <= MW'(w_sq_root_n);
                            r_re_neg <= 1'b0;
                            r_im_mag <= MW'(w_sq_root_n);
                            r_im_neg <= w_ai_n;
                        end
                        default: begin
                            r_re_neg  <= 1'b0;
                            r_im_neg  <= w_ai_n;
                            if (w_ar_n) begin
                                r_im_mag <= MW'(w_sq_half);
                            end else begin
                                r_re_mag <= MW'(w_sq_half);
                            end
                            r_dnum[0] <= ND'(w_ai_m) << FB;
                            r_dnum[1] <= ND'(w_ai_m) << FB;
                            r_dden    <= DD'(w_sq_root_n);
                            r_drem[0] <= '0;
                            r_drem[1] <= '0;
                            r_dq[0]   <= '0;
                            r_dq[1]   <= '0;
                        end
                    endcase
                end
            end
            cau_pkg::BK_DIV: begin
                for (int k = 0; k < 2; k++) begin
                    r_drem[k] <= w_drem_n[k];
                    r_dq[k]   <= w_dq_n[k];
                    r_dnum[k] <= r_dnum[k] << 1;
                end
                r_cnt <= r_cnt + CW'(1);
                if (w_div_last) begin
                    if (r_ctrl.op == cau_pkg::OP_SQRT) begin
                        if (w_ar_n) begin
                            r_re_mag <= w_dq_n[0];
                        end else begin
                            r_im_mag <= w_dq_n[0];
                        end
                    end else begin
                        r_re_mag <= w_dq_n[0];
                        r_im_mag <= w_dq_n[1];
                    end
                end
            end
            default: ;
        endcase
    end

    // clamp and encode
    always_comb begin
        w_lim_re  = r_re_neg ? LIM_NEG : LIM_POS;
        w_lim_im  = r_im_neg ? LIM_NEG : LIM_POS;
        w_over_re = (r_re_mag > w_lim_re);
        w_over_im = (r_im_mag > w_lim_im);
        w_val_re  = w_over_re ? w_lim_re[DW-1:0] : r_re_mag[DW-1:0];
        w_val_im  = w_over_im ? w_lim_im[DW-1:0] : r_im_mag[DW-1:0];
        w_fin_re  = r_re_neg ? (~w_val_re + DW'(1)) : w_val_re;
        w_fin_im  = r_im_neg ? (~w_val_im + DW'(1)) : w_val_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_re  <= w_fin_re;
            r_out_im  <= w_fin_im;
            r_out_dz  <= r_dz;
            r_out_sat <= w_over_re || w_over_im;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_res_re    = r_out_re;
    assign o_res_im    = r_out_im;
    assign o_div_zero  = r_out_dz;
    assign o_saturated = r_out_sat;

endmodule
`default_nettype wire

// ----- hw/rtl/complex_arithmetic_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex-number ALU in signed fixed point with saturation.
//
// Slave stream: tuser = op (neg, add, sub, mul, scale, div, div by real,
// sqrt); tdata = a_re, a_im, b_re, b_im from the lowest bit up.
// Master stream: tdata = res_re, res_im; tuser = div_zero, saturated.
// An input register classifies each beat and pushes it into a four-entry
// job queue; the execution stage pulls one job at a time.
// Execution stage path per op: neg, add and sub go straight from the form
// step to the output; mul and scale first fill the shared multiplier
// slots; division also runs the bit-serial divider; sqrt runs the square
// root and, for a nonzero real part, a second root and then the divider.
// A zero divisor skips the divider.
// Reset empties the queue and all valid flags. When the receiver stalls
// the result holds in the output register, the execution stage waits, and
// the queue keeps taking beats until it fills.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = cau_pkg::CAU_DATA_WIDTH,
    parameter int FRAC_BITS  = cau_pkg::CAU_FRAC_BITS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    // a_re, a_im, b_re, b_im
    input  wire logic [((4*DATA_WIDTH+7)/8)*8-1:0]      i_s_axis_tdata,
    // op
    input  wire logic [2:0]                             i_s_axis_tuser,
    output logic                                        o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    // res_re, res_im
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]           o_m_axis_tdata,
    // div_zero, saturated
    output logic [1:0]                                  o_m_axis_tuser
);

    localparam int ODW = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int CTW = $bits(cau_pkg::t_ctrl);
    localparam int EW  = CTW + 4 * DATA_WIDTH;

    logic                      w_f_valid, w_f_ready;
    cau_pkg::t_ctrl            w_f_ctrl;
    logic [4*DATA_WIDTH-1:0]   w_f_opnd;
    logic                      w_q_valid, w_q_ready;
    logic [EW-1:0]             w_q_data;
    logic [DATA_WIDTH-1:0]     w_res_re, w_res_im;
    logic                      w_dz, w_sat;

    cau_front #(
        .DW (DATA_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_op    (i_s_axis_tuser),
        .i_opnd  (i_s_axis_tdata[4*DATA_WIDTH-1:0]),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_ctrl  (w_f_ctrl),
        .o_opnd  (w_f_opnd)
    );

    cau_queue #(
        .EW    (EW),
        .DEPTH (cau_pkg::CAU_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  ({w_f_opnd, w_f_ctrl}),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_data)
    );

    cau_back #(
        .DW (DATA_WIDTH),
        .FB (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .o_ready     (w_q_ready),
        .i_ctrl      (cau_pkg::t_ctrl'(w_q_data[CTW-1:0])),
        .i_opnd      (w_q_data[EW-1:CTW]),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_res_re    (w_res_re),
        .o_res_im    (w_res_im),
        .o_div_zero  (w_dz),
        .o_saturated (w_sat)
    );

    assign o_m_axis_tdata = ODW'({w_res_im, w_res_re});
    assign o_m_axis_tuser = {w_sat, w_dz};

`ifndef SYNTHESIS
    a_dz_not_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("div_zero and saturated both set");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("nonzero result on division by zero");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire
